[hw/rtl/erm_pkg.sv]
// Shared types, constants and helper functions of the Euler rotation matrix block.
package erm_pkg;

   localparam int ANGLE_W     = 17;
   localparam int REQ_TDATA_W = 56;
   localparam int MAG_W       = 31;

   localparam int FULL_TURN    = 46080;
   localparam int QUARTER_TURN = 11520;
   localparam int EIGHTH_TURN  = 5760;

   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
   localparam logic [63:0] PI_Q60  = 64'h3243_F6A8_885A_308D;

   // Radians per angle step, scaled by 2^50.
   localparam logic [37:0] K_RAD = 38'((PI_Q60 >> 10) / 64'd23040);

   // Reciprocals, rounded up, for dividing a 30-bit value by the series denominators.
   localparam logic [30:0] COS_RCP [5] = '{
      31'(((64'd1 << 37) + 64'd89) / 64'd90),
      31'(((64'd1 << 36) + 64'd55) / 64'd56),
      31'(((64'd1 << 35) + 64'd29) / 64'd30),
      31'(((64'd1 << 34) + 64'd11) / 64'd12),
      31'((64'd1 << 31) / 64'd2)
   };
   localparam int COS_SH [5] = '{37, 36, 35, 34, 31};

   localparam logic [30:0] SIN_RCP [4] = '{
      31'(((64'd1 << 37) + 64'd71) / 64'd72),
      31'(((64'd1 << 36) + 64'd41) / 64'd42),
      31'(((64'd1 << 35) + 64'd19) / 64'd20),
      31'(((64'd1 << 33) + 64'd5) / 64'd6)
   };
   localparam int SIN_SH [4] = '{37, 36, 35, 33};

   typedef struct packed {
      logic [15:0] ang;
      logic [1:0]  quad;
      logic        swp;
      logic [12:0] u;
      logic [29:0] x;
      logic [29:0] x2;
      logic [30:0] ts;
      logic [30:0] tc;
   } lane_type;

   // Sign and magnitude; neg is never set on a zero magnitude.
   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } sm_type;

   typedef struct packed {
      sm_type s;
      sm_type c;
   } sc_type;

   typedef struct packed {
      sm_type sysx, sycx, czcy, szcx, szsx, szcy, czcx, czsx, cysx, cycx, cz, sz, sy;
   } p1_type;

   typedef struct packed {
      sm_type czsysx, czsycx, szsysx, szsycx, czcy, szcx, szsx, szcy, czcx, czsx, cysx, cycx, sy;
   } p2_type;

   // Q30 product rounded half away from zero.
   function automatic sm_type mulq(sm_type a, sm_type b);
      logic [61:0] p;
      sm_type      r;
      p     = 62'(a.mag) * 62'(b.mag) + (62'd1 << 29);
      r.mag = MAG_W'(p >> 30);
      r.neg = (a.neg ^ b.neg) && (r.mag != '0);
      return r;
   endfunction

   function automatic logic signed [32:0] to_sgn(sm_type a);
      logic signed [32:0] v;
      v = $signed({2'b00, a.mag});
      return a.neg ? -v : v;
   endfunction

endpackage

[hw/rtl/euler_rotation_matrix.sv]
// Top level: pipelined Z-Y-X Euler angle to 3x3 rotation matrix converter.
//
// Each request beat carries three angles (1/128 degree steps) and yields one response beat
// with the nine matrix elements in signed Q1.COEF_FRAC_BITS, saturated to +-1.0. The
// pipeline is 19 register stages deep and takes a new beat every cycle while the
// response side does not stall. Most of the pipeline depth is the sine and cosine series,
// which run as ten stages per angle lane, each stage doing one multiplication for each
// series (the last stage only for the cosine series).
// Every stage has its own valid bit and moves whenever the stage after it is free, so
// bubbles close up while the response side stalls.
module euler_rotation_matrix #(
   parameter int COEF_FRAC_BITS = 14
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   // angle_x, angle_y, angle_z (17 bits each), zero padded
   input  logic [erm_pkg::REQ_TDATA_W-1:0]             req_tdata,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // r11, r12, r13, r21, r22, r23, r31, r32, r33 (COEF_FRAC_BITS+2 bits each), zero padded
   output logic [((9*(COEF_FRAC_BITS+2)+7)/8)*8-1:0]  rsp_tdata
);
   import erm_pkg::*;

   localparam int OUT_W = COEF_FRAC_BITS + 2;
   localparam int RSP_W = ((9 * OUT_W + 7) / 8) * 8;
   localparam int SH    = 30 - COEF_FRAC_BITS;
   localparam logic [33:0] RND_H = (34'd1 << SH) >> 1;
   localparam logic [33:0] LIM   = 34'd1 << COEF_FRAC_BITS;

   localparam int NL     = 14;      // angle lane stages: reduce, quadrant, x, x2, series
   localparam int ST_QD  = 14;
   localparam int ST_P1  = 15;
   localparam int ST_P2  = 16;
   localparam int ST_SUM = 17;
   localparam int ST_OUT = 18;
   localparam int NS     = 19;

   localparam logic signed [17:0] TURN_S = 18'(FULL_TURN);

   logic [NS-1:0] vld_ff;
   logic [NS:0]   rdy;

   lane_type ln_ff [NL][3];
   lane_type ln_in [NL][3];
   sc_type   qd_ff [3];
   sc_type   qd_in [3];
   p1_type   p1_ff, p1_in;
   p2_type   p2_ff, p2_in;
   logic signed [32:0] sum_ff [9];
   logic signed [32:0] sum_in [9];
   logic [RSP_W-1:0]   rsp_tdata_ff, rsp_tdata_in;

   // A stage may load when it is empty or its beat moves on in the same cycle.
   always_comb begin
      rdy[NS] = rsp_tready;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign req_tready = rdy[0];
   assign rsp_tvalid = vld_ff[ST_OUT];
   assign rsp_tdata  = rsp_tdata_ff;

   always_comb begin
      lane_type cur;
      logic signed [17:0] vs;
      logic signed [17:0] a;
      logic [13:0] r;
      logic [50:0] xp;
      logic [59:0] sq;
      logic [60:0] pp;
      logic [60:0] pc;
      int i;
      r  = '0;
      xp = '0;
      sq = '0;
      pp = '0;
      pc = '0;
      i  = 0;
      for (int l = 0; l < 3; l++) begin
         cur = '0;
         vs  = 18'($signed(req_tdata[l*ANGLE_W +: ANGLE_W]));
         a   = vs;
         if (vs < 0) begin
            a = vs + TURN_S;
            if (a < 0) begin
               a = a + TURN_S;
            end
         end else if (vs >= TURN_S) begin
            a = vs - TURN_S;
         end
         cur.ang = a[15:0];
         ln_in[0][l] = cur;
      end
      for (int k = 1; k < NL; k++) begin
         for (int l = 0; l < 3; l++) begin
            cur = ln_ff[k-1][l];
            if (k == 1) begin
               if (cur.ang < 16'(QUARTER_TURN)) begin
                  cur.quad = 2'd0;
                  r = cur.ang[13:0];
               end else if (cur.ang < 16'(2 * QUARTER_TURN)) begin
                  cur.quad = 2'd1;
                  r = 14'(cur.ang - 16'(QUARTER_TURN));
               end else if (cur.ang < 16'(3 * QUARTER_TURN)) begin
                  cur.quad = 2'd2;
                  r = 14'(cur.ang - 16'(2 * QUARTER_TURN));
               end else begin
                  cur.quad = 2'd3;
                  r = 14'(cur.ang - 16'(3 * QUARTER_TURN));
               end
               // Past an eighth turn, use the complementary angle and swap sine and cosine.
               cur.swp = r > 14'(EIGHTH_TURN);
               cur.u   = cur.swp ? 13'(14'(QUARTER_TURN) - r) : r[12:0];
            end else if (k == 2) begin
               xp    = 51'(cur.u) * 51'(K_RAD) + (51'd1 << 19);
               cur.x = 30'(xp >> 20);
            end else if (k == 3) begin
               sq     = 60'(cur.x) * 60'(cur.x);
               cur.x2 = 30'(sq >> 30);
               cur.ts = ONE_Q30;
               cur.tc = ONE_Q30;
            end else begin
               i = (k - 4) >> 1;
               if ((k & 1) == 0) begin
                  pc     = 61'(cur.x2) * 61'(cur.tc);
                  cur.tc = 31'(pc >> 30);
                  if (i < 4) begin
                     pp = 61'(cur.x2) * 61'(cur.ts);
                  end else begin
                     // Last sine step scales the Horner term by x.
                     pp = 61'(cur.x) * 61'(cur.ts);
                  end
                  cur.ts = 31'(pp >> 30);
               end else begin
                  pc     = 61'(cur.tc[29:0]) * 61'(COS_RCP[i]);
                  cur.tc = ONE_Q30 - 31'(pc >> COS_SH[i]);
                  if (i < 4) begin
                     pp     = 61'(cur.ts[29:0]) * 61'(SIN_RCP[i]);
                     cur.ts = ONE_Q30 - 31'(pp >> SIN_SH[i]);
                  end
               end
            end
            ln_in[k][l] = cur;
         end
      end
   end

   always_comb begin
      logic [30:0] s0;
      logic [30:0] c0;
      for (int l = 0; l < 3; l++) begin
         s0 = ln_ff[NL-1][l].swp ? ln_ff[NL-1][l].tc : ln_ff[NL-1][l].ts;
         c0 = ln_ff[NL-1][l].swp ? ln_ff[NL-1][l].ts : ln_ff[NL-1][l].tc;
         case (ln_ff[NL-1][l].quad)
            2'd0: begin
               qd_in[l].s = '{neg: 1'b0, mag: s0};
               qd_in[l].c = '{neg: 1'b0, mag: c0};
            end
            2'd1: begin
               qd_in[l].s = '{neg: 1'b0, mag: c0};
               qd_in[l].c = '{neg: s0 != '0, mag: s0};
            end
            2'd2: begin
               qd_in[l].s = '{neg: s0 != '0, mag: s0};
               qd_in[l].c = '{neg: c0 != '0, mag: c0};
            end
            default: begin
               qd_in[l].s = '{neg: c0 != '0, mag: c0};
               qd_in[l].c = '{neg: 1'b0, mag: s0};
            end
         endcase
      end
   end

   // Lanes: 0 is X, 1 is Y, 2 is Z.
   always_comb begin
      p1_in.sysx = mulq(qd_ff[1].s, qd_ff[0].s);
      p1_in.sycx = mulq(qd_ff[1].s, qd_ff[0].c);
      p1_in.czcy = mulq(qd_ff[2].c, qd_ff[1].c);
      p1_in.szcx = mulq(qd_ff[2].s, qd_ff[0].c);
      p1_in.szsx = mulq(qd_ff[2].s, qd_ff[0].s);
      p1_in.szcy = mulq(qd_ff[2].s, qd_ff[1].c);
      p1_in.czcx = mulq(qd_ff[2].c, qd_ff[0].c);
      p1_in.czsx = mulq(qd_ff[2].c, qd_ff[0].s);
      p1_in.cysx = mulq(qd_ff[1].c, qd_ff[0].s);
      p1_in.cycx = mulq(qd_ff[1].c, qd_ff[0].c);
      p1_in.cz   = qd_ff[2].c;
      p1_in.sz   = qd_ff[2].s;
      p1_in.sy   = qd_ff[1].s;
   end

   always_comb begin
      p2_in.czsysx = mulq(p1_ff.cz, p1_ff.sysx);
      p2_in.czsycx = mulq(p1_ff.cz, p1_ff.sycx);
      p2_in.szsysx = mulq(p1_ff.sz, p1_ff.sysx);
      p2_in.szsycx = mulq(p1_ff.sz, p1_ff.sycx);
      p2_in.czcy   = p1_ff.czcy;
      p2_in.szcx   = p1_ff.szcx;
      p2_in.szsx   = p1_ff.szsx;
      p2_in.szcy   = p1_ff.szcy;
      p2_in.czcx   = p1_ff.czcx;
      p2_in.czsx   = p1_ff.czsx;
      p2_in.cysx   = p1_ff.cysx;
      p2_in.cycx   = p1_ff.cycx;
      p2_in.sy     = p1_ff.sy;
   end

   always_comb begin
      sum_in[0] = to_sgn(p2_ff.czcy);
      sum_in[1] = to_sgn(p2_ff.czsysx) - to_sgn(p2_ff.szcx);
      sum_in[2] = to_sgn(p2_ff.czsycx) + to_sgn(p2_ff.szsx);
      sum_in[3] = to_sgn(p2_ff.szcy);
      sum_in[4] = to_sgn(p2_ff.szsysx) + to_sgn(p2_ff.czcx);
      sum_in[5] = to_sgn(p2_ff.szsycx) - to_sgn(p2_ff.czsx);
      sum_in[6] = -to_sgn(p2_ff.sy);
      sum_in[7] = to_sgn(p2_ff.cysx);
      sum_in[8] = to_sgn(p2_ff.cycx);
   end

   // Round half away from zero to the output step, then clamp to one.
   always_comb begin
      logic [32:0] ab;
      logic [33:0] m;
      logic [33:0] res;
      rsp_tdata_in = '0;
      for (int j = 0; j < 9; j++) begin
         ab = sum_ff[j][32] ? 33'(-sum_ff[j]) : 33'(sum_ff[j]);
         m  = (34'(ab) + RND_H) >> SH;
         if (m > LIM) begin
            m = LIM;
         end
         res = sum_ff[j][32] ? 34'(-m) : m;
         rsp_tdata_in[j*OUT_W +: OUT_W] = res[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= (k == 0) ? req_tvalid : vld_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NL; k++) begin
         if (rdy[k]) begin
            ln_ff[k] <= ln_in[k];
         end
      end
      if (rdy[ST_QD]) begin
         qd_ff <= qd_in;
      end
      if (rdy[ST_P1]) begin
         p1_ff <= p1_in;
      end
      if (rdy[ST_P2]) begin
         p2_ff <= p2_in;
      end
      if (rdy[ST_SUM]) begin
         sum_ff <= sum_in;
      end
      if (rdy[ST_OUT]) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

endmodule
